// ===== hdl/jhfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhfp_pkg
// Shared types and constants for the JPEG frame header parser.
// ----------------------------------------------------------------------------
package jhfp_pkg;

  localparam logic [15:0] SoiMark        = 16'hFFD8;
  localparam logic [15:0] Sof0Mark       = 16'hFFC0;
  localparam logic [3:0]  NibbleMask     = 4'hF;
  localparam logic [3:0]  SofPayloadLast = 4'd14;  // index of the 15th payload byte
  localparam int unsigned NumComp        = 3;

  typedef enum logic [2:0] {
    PhSoi     = 3'd0,
    PhHeader  = 3'd1,
    PhSkip    = 3'd2,
    PhPayload = 3'd3,
    PhDone    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadSoi   = 3'd1,
    StTrunc    = 3'd2,
    StSampling = 3'd3,
    StBadLen   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FmtYuv420      = 3'd0,
    FmtYuv422      = 3'd1,
    FmtYuv444      = 3'd2,
    FmtGray        = 3'd3,
    FmtUnsupported = 3'd4
  } fmt_code_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  pixel_format;
    logic [7:0]  component_count;
  } result_t;

endpackage

// ===== hdl/jhfp_fmt_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhfp_fmt_dec
// Maps the sampling factors of the first three components to a pixel format.
// ----------------------------------------------------------------------------
module jhfp_fmt_dec
  import jhfp_pkg::*;
(
  input  logic [3:0] h_fac_i [NumComp],
  input  logic [3:0] v_fac_i [NumComp],
  output fmt_code_e  code_o
);

  logic chroma_11;
  logic chroma_12;
  logic chroma_00;

  assign chroma_11 = (h_fac_i[1] == 4'd1) && (v_fac_i[1] == 4'd1) &&
                     (h_fac_i[2] == 4'd1) && (v_fac_i[2] == 4'd1);
  assign chroma_12 = (h_fac_i[1] == 4'd1) && (v_fac_i[1] == 4'd2) &&
                     (h_fac_i[2] == 4'd1) && (v_fac_i[2] == 4'd2);
  assign chroma_00 = (h_fac_i[1] == 4'd0) && (v_fac_i[1] == 4'd0) &&
                     (h_fac_i[2] == 4'd0) && (v_fac_i[2] == 4'd0);

  // First match wins, in the order the formats are listed.
  always_comb begin
    if (chroma_11 && h_fac_i[0] == 4'd2 && v_fac_i[0] == 4'd2) begin
      code_o = FmtYuv420;
    end else if (chroma_11 && h_fac_i[0] == 4'd4 && v_fac_i[0] == 4'd1) begin
      code_o = FmtUnsupported;
    end else if (chroma_11 && h_fac_i[0] == 4'd2 && v_fac_i[0] == 4'd1) begin
      code_o = FmtYuv422;
    end else if (chroma_11 && h_fac_i[0] == 4'd1 && v_fac_i[0] == 4'd1) begin
      code_o = FmtYuv444;
    end else if (chroma_12 && h_fac_i[0] == 4'd1 && v_fac_i[0] == 4'd2) begin
      code_o = FmtYuv444;
    end else if (chroma_11 && h_fac_i[0] == 4'd1 && v_fac_i[0] == 4'd2) begin
      code_o = FmtUnsupported;
    end else if (chroma_00) begin
      code_o = FmtGray;
    end else begin
      code_o = FmtUnsupported;
    end
  end

endmodule

// ===== hdl/jpeg_header_format_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_header_format_parser
// Checks the start-of-image marker, skips segments and decodes the SOF0 frame
// header of a JPEG byte stream into size, component count and pixel format.
// ----------------------------------------------------------------------------
// Results are registered in the output stage before they appear on the
// master side.
// Throughput: one byte per cycle while the skid entry is empty; a two-entry
// output stage keeps the input open while one result waits downstream.
// Reset: rst_ni clears the parser to the start-marker check and empties the
// output stage.
module jpeg_header_format_parser
  import jhfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] width, [31:16] height, [33:32] pixel_format,
  // [41:34] component_count, [47:42] zero
  output logic [47:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] marker_q, marker_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] height_q, height_d;
  logic [15:0] width_q, width_d;
  logic [7:0]  comps_q, comps_d;
  logic [3:0]  h_fac_q [NumComp];
  logic [3:0]  h_fac_d [NumComp];
  logic [3:0]  v_fac_q [NumComp];
  logic [3:0]  v_fac_d [NumComp];

  logic        accept;
  logic [7:0]  in_byte;
  logic        res_valid;
  result_t     res;
  fmt_code_e   fmt_code;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic [1:0]  comp_sel;
  logic        comp_hit;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_byte = s_axis_tdata_i;
  assign seg_len = {len_hi_q, in_byte};
  assign skip_dec = skip_q - 16'd1;

  jhfp_fmt_dec u_fmt_dec (
    .h_fac_i (h_fac_q),
    .v_fac_i (v_fac_q),
    .code_o  (fmt_code)
  );

  // The sampling-factor bytes of the component triples are payload bytes 7, 10 and 13.
  always_comb begin
    comp_hit = 1'b1;
    comp_sel = 2'd0;
    case (idx_q)
      4'd7:    comp_sel = 2'd0;
      4'd10:   comp_sel = 2'd1;
      4'd13:   comp_sel = 2'd2;
      default: comp_hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    skip_d   = skip_q;
    marker_d = marker_q;
    len_hi_d = len_hi_q;
    height_d = height_q;
    width_d  = width_q;
    comps_d  = comps_q;
    h_fac_d  = h_fac_q;
    v_fac_d  = v_fac_q;
    res_valid = 1'b0;
    res       = '{status: StOk, width: '0, height: '0, pixel_format: '0,
                  component_count: '0};

    unique case (phase_q)
      PhSoi: begin
        if (idx_q == 4'd0) begin
          marker_d = {in_byte, 8'h00};
          idx_d    = 4'd1;
        end else begin
          marker_d = {marker_q[15:8], in_byte};
          idx_d    = 4'd0;
          if ({marker_q[15:8], in_byte} != SoiMark) begin
            res_valid  = 1'b1;
            res.status = StBadSoi;
            phase_d    = PhDone;
          end else begin
            phase_d = PhHeader;
          end
        end
      end
      PhHeader: begin
        case (idx_q)
          4'd0: begin
            marker_d = {in_byte, 8'h00};
            idx_d    = 4'd1;
          end
          4'd1: begin
            marker_d = {marker_q[15:8], in_byte};
            idx_d    = 4'd2;
          end
          4'd2: begin
            len_hi_d = in_byte;
            idx_d    = 4'd3;
          end
          default: begin
            idx_d = 4'd0;
            if (marker_q == Sof0Mark) begin
              phase_d = PhPayload;
            end else if (seg_len < 16'd2) begin
              res_valid  = 1'b1;
              res.status = StBadLen;
              phase_d    = PhDone;
            end else begin
              skip_d  = seg_len - 16'd2;
              phase_d = (seg_len == 16'd2) ? PhHeader : PhSkip;
            end
          end
        endcase
      end
      PhSkip: begin
        if (skip_q != 16'd0) begin
          skip_d = skip_dec;
        end
        if (skip_q == 16'd0 || skip_dec == 16'd0) begin
          phase_d = PhHeader;
          idx_d   = 4'd0;
        end
      end
      PhPayload: begin
        case (idx_q)
          4'd1:    height_d = {in_byte, 8'h00};
          4'd2:    height_d = {height_q[15:8], in_byte};
          4'd3:    width_d  = {in_byte, 8'h00};
          4'd4:    width_d  = {width_q[15:8], in_byte};
          4'd5:    comps_d  = in_byte;
          default: ;
        endcase
        if (comp_hit && ({6'd0, comp_sel} < comps_q)) begin
          h_fac_d[comp_sel] = in_byte[7:4];
          v_fac_d[comp_sel] = in_byte[3:0] & NibbleMask;
        end
        idx_d = idx_q + 4'd1;
        if (idx_q == SofPayloadLast) begin
          // The factors of the last component were registered with the byte
          // before, so the decode already sees all three components here.
          idx_d     = 4'd0;
          res_valid = 1'b1;
          phase_d   = PhDone;
          res.component_count = comps_q;
          if (fmt_code == FmtUnsupported) begin
            res.status = StSampling;
          end else begin
            res.status       = StOk;
            res.width        = width_q;
            res.height       = height_q;
            res.pixel_format = fmt_code[1:0];
          end
        end
      end
      PhDone: ;
      default: ;
    endcase

    if (s_axis_tlast_i) begin
      if (!res_valid && phase_q != PhDone) begin
        res_valid = 1'b1;
        res       = '{status: StTrunc, width: '0, height: '0, pixel_format: '0,
                      component_count: '0};
      end
      phase_d  = PhSoi;
      idx_d    = '0;
      skip_d   = '0;
      marker_d = '0;
      len_hi_d = '0;
      height_d = '0;
      width_d  = '0;
      comps_d  = '0;
      for (int i = 0; i < NumComp; i++) begin
        h_fac_d[i] = '0;
        v_fac_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSoi;
      idx_q    <= '0;
      skip_q   <= '0;
      marker_q <= '0;
      len_hi_q <= '0;
      height_q <= '0;
      width_q  <= '0;
      comps_q  <= '0;
      for (int i = 0; i < NumComp; i++) begin
        h_fac_q[i] <= '0;
        v_fac_q[i] <= '0;
      end
    end else if (accept) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      skip_q   <= skip_d;
      marker_q <= marker_d;
      len_hi_q <= len_hi_d;
      height_q <= height_d;
      width_q  <= width_d;
      comps_q  <= comps_d;
      h_fac_q  <= h_fac_d;
      v_fac_q  <= v_fac_d;
    end
  end

  // Output stage: a head register toward the bus and one skid entry behind it.
  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    produce;
  logic    head_free;

  assign produce   = accept && res_valid;
  assign head_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (head_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= produce;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (produce) begin
          skid_q <= res;
        end
      end else if (produce) begin
        out_q <= res;
      end
    end else if (produce) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {6'd0, out_q.component_count, out_q.pixel_format,
                            out_q.height, out_q.width};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JPEG frame header parser. A short table of
// hand-built files is sent first, then random files that are mostly
// well-formed. Every request is also fed to a behavioral parser in the bench,
// and each response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import jhfp_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ItemsPerPass = 500;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned MaxPrinted   = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;   // the expected response is written into the table
    result_t    want;
  } byte_req_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast_i  = 1'b0;    // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [15:0] width, [31:16] height, [33:32] pixel_format,
  // [41:34] component_count, [47:42] zero
  logic [47:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;            // [2:0] status

  byte_req_t   stim_q[$];
  result_t     header_results_q[$];
  byte_req_t   cur_req = '0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // Parser state kept by the bench.
  phase_e      ph;
  logic [3:0]  idx;
  logic [15:0] skip_left;
  logic [15:0] mark;
  logic [7:0]  len_hi;
  logic [15:0] img_h;
  logic [15:0] img_w;
  logic [7:0]  ncomp;
  logic [3:0]  hf[NumComp];
  logic [3:0]  vf[NumComp];

  jpeg_header_format_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (err_count < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  function automatic void parser_restart();
    ph        = PhSoi;
    idx       = '0;
    skip_left = '0;
    mark      = '0;
    len_hi    = '0;
    img_h     = '0;
    img_w     = '0;
    ncomp     = '0;
    for (int i = 0; i < NumComp; i++) begin
      hf[i] = '0;
      vf[i] = '0;
    end
  endfunction

  function automatic fmt_code_e subsampling_of();
    logic [23:0] f;
    f = {hf[0], vf[0], hf[1], vf[1], hf[2], vf[2]};
    case (f)
      24'h221111: return FmtYuv420;
      24'h411111: return FmtUnsupported;
      24'h211111: return FmtYuv422;
      24'h111111: return FmtYuv444;
      24'h121212: return FmtYuv444;
      24'h121111: return FmtUnsupported;
      default: begin
        // The chroma components carry no factors: grayscale.
        if (f[15:0] == '0) return FmtGray;
        return FmtUnsupported;
      end
    endcase
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output logic got, output result_t res);
    logic [15:0] seg_len;
    int unsigned c;
    fmt_code_e   fmt;
    got = 1'b0;
    res = '0;
    if (ph == PhDone) begin
      if (last) parser_restart();
    end else begin
      case (ph)
        PhSoi: begin
          if (idx == 4'd0) begin
            mark = {b, 8'h00};
            idx  = 4'd1;
          end else begin
            mark[7:0] = b;
            idx       = 4'd0;
            if (mark != SoiMark) begin
              res.status = StBadSoi;
              got        = 1'b1;
              ph         = PhDone;
            end else begin
              ph = PhHeader;
            end
          end
        end
        PhHeader: begin
          case (idx)
            4'd0: begin mark = {b, 8'h00}; idx = 4'd1; end
            4'd1: begin mark[7:0] = b; idx = 4'd2; end
            4'd2: begin len_hi = b; idx = 4'd3; end
            default: begin
              seg_len = {len_hi, b};
              idx     = 4'd0;
              if (mark == Sof0Mark) begin
                ph = PhPayload;
              end else if (seg_len < 16'd2) begin
                res.status = StBadLen;
                got        = 1'b1;
                ph         = PhDone;
              end else begin
                skip_left = seg_len - 16'd2;
                ph        = (skip_left != 16'd0) ? PhSkip : PhHeader;
              end
            end
          endcase
        end
        PhSkip: begin
          if (skip_left > 16'd0) skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) begin
            ph  = PhHeader;
            idx = 4'd0;
          end
        end
        default: begin
          case (idx)
            4'd1: img_h = {b, 8'h00};
            4'd2: img_h[7:0] = b;
            4'd3: img_w = {b, 8'h00};
            4'd4: img_w[7:0] = b;
            4'd5: ncomp = b;
            4'd7, 4'd10, 4'd13: begin
              c = (idx - 7) / 3;
              if (c < ncomp) begin
                hf[c] = b[7:4];
                vf[c] = b[3:0] & NibbleMask;
              end
            end
            default: ;
          endcase
          if (idx == SofPayloadLast) begin
            idx = 4'd0;
            fmt = subsampling_of();
            got = 1'b1;
            ph  = PhDone;
            res.component_count = ncomp;
            if (fmt == FmtUnsupported) begin
              res.status = StSampling;
            end else begin
              res.status       = StOk;
              res.width        = img_w;
              res.height       = img_h;
              res.pixel_format = fmt[1:0];
            end
          end else begin
            idx = idx + 4'd1;
          end
        end
      endcase
      if (last) begin
        if (!got) begin
          res.status = StTrunc;
          got        = 1'b1;
        end
        parser_restart();
      end
    end
  endtask

  always @(posedge clk_i) begin : monitor
    logic    got;
    result_t res;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        parse_byte(s_axis_tdata_i, s_axis_tlast_i, got, res);
        if (cur_req.typed) begin
          if (!got || res != cur_req.want) begin
            flag_mismatch("table row vs parser", {13'd0, res.status},
                          {13'd0, cur_req.want.status});
          end
          header_results_q.push_back(cur_req.want);
        end else if (got) begin
          header_results_q.push_back(res);
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (header_results_q.size() == 0) begin
          flag_mismatch("response with no request pending", {13'd0, m_axis_tuser_o}, '0);
        end else begin
          want = header_results_q.pop_front();
          if (m_axis_tuser_o != want.status)
            flag_mismatch("status", {13'd0, m_axis_tuser_o}, {13'd0, want.status});
          if (m_axis_tdata_o[15:0] != want.width)
            flag_mismatch("width", m_axis_tdata_o[15:0], want.width);
          if (m_axis_tdata_o[31:16] != want.height)
            flag_mismatch("height", m_axis_tdata_o[31:16], want.height);
          if (m_axis_tdata_o[33:32] != want.pixel_format)
            flag_mismatch("pixel_format", {14'd0, m_axis_tdata_o[33:32]},
                          {14'd0, want.pixel_format});
          if (m_axis_tdata_o[41:34] != want.component_count)
            flag_mismatch("component_count", {8'd0, m_axis_tdata_o[41:34]},
                          {8'd0, want.component_count});
          if (m_axis_tdata_o[47:42] != '0)
            flag_mismatch("tdata padding", {10'd0, m_axis_tdata_o[47:42]}, '0);
        end
      end
    end
  end

  task automatic add_row(input logic [7:0] b, input logic last);
    byte_req_t r;
    r      = '0;
    r.data = b;
    r.last = last;
    stim_q.push_back(r);
  endtask

  task automatic add_row_want(input logic [7:0] b, input logic last, input status_e st,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [1:0] fmt, input logic [7:0] cnt);
    byte_req_t r;
    r       = '0;
    r.data  = b;
    r.last  = last;
    r.typed = 1'b1;
    r.want  = '{status: st, width: w, height: h, pixel_format: fmt, component_count: cnt};
    stim_q.push_back(r);
  endtask

  function automatic logic [15:0] pick_dimension();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Builds one file as a run of requests, mostly a well-formed header chain
  // with random content, sometimes broken or cut short.
  task automatic gen_file();
    logic [7:0]  file_q[$];
    logic [7:0]  fac[3];
    logic [7:0]  cnt;
    logic [7:0]  mk;
    logic [15:0] seg_len;
    logic [15:0] dim_h;
    logic [15:0] dim_w;
    int unsigned kind;
    int unsigned cut;
    byte_req_t   r;
    bit          broken;
    kind   = $urandom_range(99);
    broken = 1'b0;
    if (kind < 8) begin
      file_q.push_back($urandom_range(1) ? 8'hFF : 8'($urandom));
      file_q.push_back(8'($urandom));
    end else if (kind < 15) begin
      repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom));
    end else begin
      file_q.push_back(SoiMark[15:8]);
      file_q.push_back(SoiMark[7:0]);
      repeat ($urandom_range(3)) begin
        mk = 8'($urandom);
        if (mk == Sof0Mark[7:0]) mk = 8'hC4;
        file_q.push_back($urandom_range(9) == 0 ? 8'($urandom) : 8'hFF);
        file_q.push_back(mk);
        case ($urandom_range(9))
          0:       seg_len = 16'd2;
          1:       seg_len = 16'($urandom_range(3, 300));
          default: seg_len = 16'($urandom_range(3, 20));
        endcase
        file_q.push_back(seg_len[15:8]);
        file_q.push_back(seg_len[7:0]);
        repeat (seg_len - 2) file_q.push_back(8'($urandom));
      end
      if (kind < 25) begin
        // Segment length below the size of the length field itself.
        file_q.push_back(8'hFF);
        file_q.push_back(8'hE1);
        file_q.push_back(8'h00);
        file_q.push_back(8'($urandom_range(1)));
        broken = 1'b1;
      end
      if (!broken) begin
        case ($urandom_range(7))
          0: fac = '{8'h22, 8'h11, 8'h11};
          1: fac = '{8'h41, 8'h11, 8'h11};
          2: fac = '{8'h21, 8'h11, 8'h11};
          3: fac = '{8'h11, 8'h11, 8'h11};
          4: fac = '{8'h12, 8'h12, 8'h12};
          5: fac = '{8'h12, 8'h11, 8'h11};
          6: fac = '{8'h11, 8'h00, 8'h00};
          default: fac = '{8'($urandom), 8'($urandom), 8'($urandom)};
        endcase
        case ($urandom_range(9))
          6:       cnt = 8'd1;
          7:       cnt = 8'd0;
          8:       cnt = 8'd2;
          9:       cnt = 8'($urandom);
          default: cnt = 8'd3;
        endcase
        dim_h = pick_dimension();
        dim_w = pick_dimension();
        file_q.push_back(Sof0Mark[15:8]);
        file_q.push_back(Sof0Mark[7:0]);
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));        // sample precision
        file_q.push_back(dim_h[15:8]);
        file_q.push_back(dim_h[7:0]);
        file_q.push_back(dim_w[15:8]);
        file_q.push_back(dim_w[7:0]);
        file_q.push_back(cnt);
        for (int i = 0; i < 3; i++) begin
          file_q.push_back(8'($urandom));      // component id
          file_q.push_back(fac[i]);
          file_q.push_back(8'($urandom));      // quantization table
        end
      end
    end
    repeat ($urandom_range(3)) file_q.push_back(8'($urandom));
    if ($urandom_range(99) < 12) begin
      cut = $urandom_range(file_q.size() - 1);
      while (file_q.size() > cut + 1) void'(file_q.pop_back());
    end
    for (int i = 0; i < file_q.size(); i++) begin
      r      = '0;
      r.data = file_q[i];
      r.last = (i == file_q.size() - 1);
      stim_q.push_back(r);
    end
  endtask

  // Entered and left right after a falling edge.
  task automatic send_req(input byte_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r.data;
    s_axis_tlast_i  <= r.last;
    cur_req         <= r;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_req(stim_q.pop_front());
  endtask

  task automatic wait_drained();
    while (header_results_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    parser_restart();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 36;
    rx_idle_pct = 53;

    // Early end on the very first byte.
    add_row_want(8'hFF, 1'b1, StTrunc, 16'h0000, 16'h0000, 2'd0, 8'd0);
    // Bad start marker, then a byte that is ignored up to the end of file.
    add_row(8'h00, 1'b0);
    add_row_want(8'hFF, 1'b0, StBadSoi, 16'h0000, 16'h0000, 2'd0, 8'd0);
    add_row(8'h5A, 1'b1);
    // Empty segment, then a segment length of one, reported on the last byte.
    add_row(8'hFF, 1'b0);
    add_row(8'hD8, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hE0, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hE1, 1'b0);
    add_row(8'h00, 1'b0);
    add_row_want(8'h01, 1'b1, StBadLen, 16'h0000, 16'h0000, 2'd0, 8'd0);
    // Largest frame, 255 components of which only three count, 4:2:0.
    add_row(8'hFF, 1'b0);
    add_row(8'hD8, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hC0, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h11, 1'b0);
    add_row(8'h08, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h22, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h11, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h03, 1'b0);
    add_row(8'h11, 1'b0);
    add_row_want(8'h01, 1'b1, StOk, 16'hFFFF, 16'hFFFF, 2'd0, 8'hFF);
    send_all();

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0:       begin tx_idle_pct = 36; rx_idle_pct = 53; end
        1:       begin tx_idle_pct = 53; rx_idle_pct = 36; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      while (stim_q.size() < ItemsPerPass) gen_file();
      send_all();
      if (pass == 0) begin
        // Hold the input off until the output side has caught up.
        s_axis_tvalid_i <= 1'b0;
        wait_drained();
        @(negedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/jhfp_pkg.sv
hdl/jhfp_fmt_dec.sv
hdl/jpeg_header_format_parser.sv
tb/sv/tb_top.sv
